// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL, included by the top-level file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frgf_pkg.sv =====
// Package for the font ROM glyph fetch unit: types, constants, address map
package frgf_pkg;

  localparam logic [5:0] WIDE_BYTES   = 6'd32;
  localparam logic [5:0] NARROW_BYTES = 6'd16;

  localparam logic [7:0] READ_CMD = 8'h03;

  // wide glyph address map
  localparam logic [7:0]  ROW_FIRST  = 8'hB0;
  localparam logic [7:0]  ROW_LAST   = 8'hF7;
  localparam logic [7:0]  COL_FIRST  = 8'hA1;
  localparam logic [12:0] ROW_STRIDE = 13'd94;
  localparam logic [12:0] INDEX_BIAS = 13'd846;

  // narrow glyph address map
  localparam logic [15:0] SYM_FIRST   = 16'hA3A1;
  localparam logic [15:0] SYM_LAST    = 16'hA3FE;
  localparam logic [23:0] SYM_BASE    = 24'h03B7D0;
  localparam logic [15:0] ASCII_FIRST = 16'h0020;
  localparam logic [15:0] ASCII_LAST  = 16'h007E;
  localparam logic [23:0] ASCII_BASE  = 24'h03B7C0;

  // blank codes
  localparam logic [15:0] BLANK_CODE = 16'hA3A0;
  localparam logic [15:0] NULL_CODE  = 16'h0000;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] char_code;
    logic        wide_glyph;
    logic        miso;
  } item_t;

  typedef struct packed {
    logic       rom_select_n;
    logic       rom_clock;
    logic       rom_mosi;
    logic [7:0] glyph_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       busy_res;
  } result_t;

endpackage

// ===== hw/rtl/font_rom_glyph_fetch_unit.sv =====
// Font ROM glyph fetch unit, top level.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// op_i = start with char_code_i and wide_glyph_i, or tick, which moves the
// serial ROM bus by half a clock period and samples miso_i when due.
// Output channel (out_valid_o / out_stall_i) gives exactly one result per
// item: the ROM pins (select, clock, mosi) as they stand after the item,
// plus a completed glyph byte with its valid and last flags and busy.
// A start sends read command 0x03 and a 24-bit address, then assembles
// 32 (wide) or 16 (narrow) bytes; blank codes yield 16 zero bytes, one per
// tick, with the bus left idle. A start during a fetch drops it.
// A transferred item enters the input register; when the result register
// can advance, the sequencer step writes its result there, and the outputs
// show the result register. Throughput: one item per cycle while
// out_stall_i is low, set by the single step of the sequencer between them.
// When out_stall_i holds a result, the input register fills and then
// in_stall_o rises; nothing is lost. Reset empties both registers and puts
// the sequencer in idle with the ROM deselected.
`include "assert_macros.svh"

module font_rom_glyph_fetch_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [15:0] char_code_i,
  input  logic        wide_glyph_i,
  input  logic        miso_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        rom_select_n_o,
  output logic        rom_clock_o,
  output logic        rom_mosi_o,
  output logic [7:0]  glyph_byte_o,
  output logic        byte_valid_o,
  output logic        last_byte_o,
  output logic        busy_res_o
);

  logic              in_valid_q;
  frgf_pkg::item_t   item_q;
  logic              out_valid_q;
  frgf_pkg::result_t res_q;
  frgf_pkg::result_t res_d;
  logic              advance;
  logic              fire;
  logic              in_xfer;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '{rom_select_n: 1'b1, rom_clock: 1'b0, rom_mosi: 1'b0,
                       glyph_byte: 8'd0, byte_valid: 1'b0, last_byte: 1'b0,
                       busy_res: 1'b0};
    end else begin
      in_valid_q <= in_xfer || (in_valid_q && !advance);
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        res_q <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{op: frgf_pkg::op_e'(op_i), char_code: char_code_i,
                  wide_glyph: wide_glyph_i, miso: miso_i};
    end
  end

  frgf_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign rom_select_n_o = res_q.rom_select_n;
  assign rom_clock_o    = res_q.rom_clock;
  assign rom_mosi_o     = res_q.rom_mosi;
  assign glyph_byte_o   = res_q.glyph_byte;
  assign byte_valid_o   = res_q.byte_valid;
  assign last_byte_o    = res_q.last_byte;
  assign busy_res_o     = res_q.busy_res;

  `ASSERT_IMPLY(a_idle_bus_quiet, clk_i, rst_ni, out_valid_q && !res_q.busy_res, res_q.rom_select_n && !res_q.rom_clock && !res_q.rom_mosi, "bus active while idle")
  `ASSERT_IMPLY(a_last_ends_fetch, clk_i, rst_ni, out_valid_q && res_q.last_byte, res_q.byte_valid && !res_q.busy_res, "last byte without end of fetch")
  `ASSERT_NEXT(a_result_from_item, clk_i, rst_ni, !out_valid_q && !in_valid_q, !out_valid_q, "result without an item")

endmodule

// ===== hw/rtl/frgf_addr.sv =====
// ROM address lookup and blank detection for a character code
module frgf_addr (
  input  logic [15:0] char_code_i,
  input  logic        wide_glyph_i,
  output logic [23:0] rom_addr_o,
  output logic        blank_o
);

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [7:0]  row_full;
  logic [7:0]  col_full;
  logic [12:0] row_off;
  logic [12:0] glyph_idx;
  logic        wide_ok;
  logic [15:0] sym_off;
  logic [15:0] ascii_off;
  logic [23:0] wide_addr;
  logic [23:0] narrow_addr;

  assign hi = char_code_i[15:8];
  assign lo = char_code_i[7:0];

  assign blank_o = (char_code_i == frgf_pkg::BLANK_CODE) ||
                   (char_code_i == frgf_pkg::NULL_CODE);

  always_comb begin
    wide_ok   = (hi >= frgf_pkg::ROW_FIRST) && (hi <= frgf_pkg::ROW_LAST) &&
                (lo >= frgf_pkg::COL_FIRST);
    row_full  = hi - frgf_pkg::ROW_FIRST;
    col_full  = lo - frgf_pkg::COL_FIRST;
    row_off   = 13'(row_full[6:0]) * frgf_pkg::ROW_STRIDE;
    glyph_idx = row_off + 13'(col_full) + frgf_pkg::INDEX_BIAS;
    wide_addr = wide_ok ? 24'({glyph_idx, 5'b0}) : 24'd0;

    sym_off   = char_code_i - frgf_pkg::SYM_FIRST;
    ascii_off = char_code_i - frgf_pkg::ASCII_FIRST;
    if ((char_code_i >= frgf_pkg::SYM_FIRST) && (char_code_i <= frgf_pkg::SYM_LAST)) begin
      narrow_addr = 24'({sym_off[6:0], 4'b0}) + frgf_pkg::SYM_BASE;
    end else if ((char_code_i >= frgf_pkg::ASCII_FIRST) &&
                 (char_code_i <= frgf_pkg::ASCII_LAST)) begin
      narrow_addr = 24'({ascii_off[6:0], 4'b0}) + frgf_pkg::ASCII_BASE;
    end else begin
      narrow_addr = 24'd0;
    end

    rom_addr_o = wide_glyph_i ? wide_addr : narrow_addr;
  end

endmodule

// ===== hw/rtl/frgf_engine.sv =====
// Serial bus sequencer: one step per item, state held across items
module frgf_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  frgf_pkg::item_t  item_i,
  output frgf_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2,
    PH_FILL = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] cmd_q, cmd_d;
  logic [5:0]  hbc_q, hbc_d;
  logic [7:0]  rx_q, rx_d;
  logic [5:0]  left_q, left_d;
  logic [23:0] rom_addr;
  logic        blank;
  logic        on_bus;

  frgf_addr u_addr (
    .char_code_i  (item_i.char_code),
    .wide_glyph_i (item_i.wide_glyph),
    .rom_addr_o   (rom_addr),
    .blank_o      (blank)
  );

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    hbc_d   = hbc_q;
    rx_d    = rx_q;
    left_d  = left_q;
    result_o.glyph_byte = 8'd0;
    result_o.byte_valid = 1'b0;
    result_o.last_byte  = 1'b0;

    if (item_i.op == frgf_pkg::OP_START) begin
      hbc_d = 6'd0;
      rx_d  = 8'd0;
      if (blank) begin
        phase_d = PH_FILL;
        cmd_d   = 32'd0;
        left_d  = frgf_pkg::NARROW_BYTES;
      end else begin
        phase_d = PH_SEND;
        cmd_d   = {frgf_pkg::READ_CMD, rom_addr};
        left_d  = item_i.wide_glyph ? frgf_pkg::WIDE_BYTES : frgf_pkg::NARROW_BYTES;
      end
    end else begin
      case (phase_q)
        PH_SEND: begin
          if (hbc_q == 6'd63) begin
            phase_d = PH_RECV;
            hbc_d   = 6'd0;
          end else begin
            hbc_d = hbc_q + 6'd1;
            // falling edge brings the next bit
            if (!hbc_d[0]) begin
              cmd_d = {cmd_q[30:0], 1'b0};
            end
          end
        end
        PH_RECV: begin
          if (!hbc_q[0]) begin
            rx_d = {rx_q[6:0], item_i.miso};
            if (hbc_q == 6'd14) begin
              result_o.glyph_byte = rx_d;
              result_o.byte_valid = 1'b1;
              left_d = left_q - 6'd1;
              if (left_d == 6'd0) begin
                result_o.last_byte = 1'b1;
                phase_d = PH_IDLE;
                hbc_d   = 6'd0;
                cmd_d   = 32'd0;
              end else begin
                hbc_d = 6'd15;
              end
            end else begin
              hbc_d = {2'b0, hbc_q[3:0] + 4'd1};
            end
          end else begin
            hbc_d = {2'b0, hbc_q[3:0] + 4'd1};
          end
        end
        PH_FILL: begin
          result_o.byte_valid = 1'b1;
          left_d = left_q - 6'd1;
          if (left_d == 6'd0) begin
            result_o.last_byte = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // idle tick: hold
        end
      endcase
    end

    on_bus = (phase_d == PH_SEND) || (phase_d == PH_RECV);
    result_o.rom_select_n = !on_bus;
    result_o.rom_clock    = on_bus && hbc_d[0];
    result_o.rom_mosi     = (phase_d == PH_SEND) && cmd_d[31];
    result_o.busy_res     = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= 32'd0;
      hbc_q   <= 6'd0;
      rx_q    <= 8'd0;
      left_q  <= 6'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      hbc_q   <= hbc_d;
      rx_q    <= rx_d;
      left_q  <= left_d;
    end
  end

endmodule
